FILE: hdl/i2cram_pkg.sv
// i2cram_pkg: shared constants for the I2C register access master.
// Widths, request codes, default burst limit, APB map, resets.
// No dependencies.
package i2cram_pkg;

  localparam int BYTE_W      = 8;
  localparam int REQ_W       = 2;
  localparam int BURST_LEN_W = 9;
  localparam int MAX_BURST_DEF = 256;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DEV_ADDR    = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [BYTE_W-1:0] DEV_ADDR_RST    = 8'd230;
  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

  // Command codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BURST = 2'd2;
  localparam logic [REQ_W-1:0] REQ_WAKE  = 2'd3;

endpackage

FILE: hdl/i2cram_ifs.sv
// i2cram_ifs: valid/ready channel interfaces for tick requests and results.
// Depends on i2cram_pkg for field widths.
interface i2cram_req_if
  import i2cram_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   start_cmd;
  logic [REQ_W-1:0]       req_type;
  logic [BYTE_W-1:0]      reg_addr;
  logic [BYTE_W-1:0]      wr_data;
  logic [BURST_LEN_W-1:0] burst_len;
  logic                   sda_in;

  modport source (output valid, start_cmd, req_type, reg_addr, wr_data, burst_len, sda_in,
                  input ready);
  modport sink   (input valid, start_cmd, req_type, reg_addr, wr_data, burst_len, sda_in,
                  output ready);
endinterface

interface i2cram_res_if
  import i2cram_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              scl_out;
  logic              sda_out;
  logic              sda_drive;
  logic              busy_res;
  logic              read_valid;
  logic [BYTE_W-1:0] read_byte;
  logic              last_byte;
  logic              cmd_done;
  logic              nack_error;

  modport source (output valid, scl_out, sda_out, sda_drive, busy_res, read_valid, read_byte,
                  last_byte, cmd_done, nack_error, input ready);
  modport sink   (input valid, scl_out, sda_out, sda_drive, busy_res, read_valid, read_byte,
                  last_byte, cmd_done, nack_error, output ready);
endinterface

FILE: hdl/i2c_register_access_master_top.sv
// i2c_register_access_master_top: I2C register write / read / burst read / wake engine.
// Depends on i2cram_pkg and the channel interfaces in i2cram_ifs.sv.
//
//   channel   dir  handshake         payload
//   req_ch    in   valid/ready       start_cmd req_type reg_addr wr_data burst_len sda_in
//   res_ch    out  valid/ready       scl_out sda_out sda_drive busy_res read_valid
//                                    read_byte last_byte cmd_done nack_error
//   apb       in   psel/penable      paddr pwdata pwrite -> prdata, pready tied high
//
// Every request transfer is one bus tick and yields exactly one result transfer.
// The sequencer step is combinational into the result register, so a tick is accepted
// every cycle unless stalled; the result register frees in the same cycle it is taken.
// A stalled result holds the sequencer: req_ch.ready = !res_ch.valid | res_ch.ready.
// rst (synchronous) returns the sequencer to idle and loads register defaults
// (address 230, timeout 250); no result is pending after reset.
module i2c_register_access_master_top
  import i2cram_pkg::*;
#(
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic                clk,
  input  logic                rst,
  i2cram_req_if.sink          req_ch,
  i2cram_res_if.source        res_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int BLW  = $clog2(MAX_BURST + 1);
  localparam int CMPW = (BLW > BURST_LEN_W) ? BLW : BURST_LEN_W;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_ADDR_W = 4'd2,
    PH_ACK1   = 4'd3,
    PH_REG    = 4'd4,
    PH_ACK2   = 4'd5,
    PH_DATA   = 4'd6,
    PH_ACK3   = 4'd7,
    PH_START2 = 4'd8,
    PH_ADDR_R = 4'd9,
    PH_ACK4   = 4'd10,
    PH_READ   = 4'd11,
    PH_MACK   = 4'd12,
    PH_STOP   = 4'd13
  } phase_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              last_byte;
    logic              cmd_done;
    logic              nack_error;
  } res_t;

  // ---------------------------------------------------------------- config
  logic [BYTE_W-1:0] device_write_address;
  logic [BYTE_W-1:0] ack_timeout;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  // word decode on paddr[2]; low address bits are ignored
  assign prdata = (paddr[2] == REG_ACK_TIMEOUT) ? PDATA_W'(ack_timeout)
                                               : PDATA_W'(device_write_address);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_write_address <= DEV_ADDR_RST;
      ack_timeout          <= ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEV_ADDR) begin
        device_write_address <= pwdata[BYTE_W-1:0];
      end else begin
        ack_timeout <= pwdata[BYTE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer state
  phase_t            phase, phase_next;
  logic [3:0]        bit_index, bit_index_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [BLW-1:0]    bytes_left, bytes_left_next;
  logic [BYTE_W-1:0] ack_wait_count, ack_wait_count_next;
  logic [REQ_W-1:0]  latched_command, latched_command_next;
  logic [BYTE_W-1:0] latched_register, latched_register_next;
  logic [BYTE_W-1:0] latched_data, latched_data_next;
  logic              error_flag, error_flag_next;

  res_t res_next, res_q;
  logic res_valid;
  logic req_fire;

  assign req_ch.ready = ~res_valid | res_ch.ready;
  assign req_fire     = req_ch.valid & req_ch.ready;

  // helpers
  logic [1:0]        idx;
  logic [1:0]        stop_idx;
  logic [BYTE_W-1:0] shift_in;
  logic [CMPW-1:0]   bl_ext;
  logic [CMPW-1:0]   max_ext;

  assign bl_ext   = CMPW'(req_ch.burst_len);
  assign max_ext  = CMPW'(MAX_BURST);
  assign idx      = bit_index[1:0];
  assign stop_idx = (bit_index > 4'd2) ? 2'd2 : bit_index[1:0];
  assign shift_in = {shift_byte[BYTE_W-2:0], req_ch.sda_in};

  always_comb begin
    phase_next            = phase;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    ack_wait_count_next   = ack_wait_count;
    latched_command_next  = latched_command;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    error_flag_next       = error_flag;

    res_next            = '0;
    res_next.scl_out    = 1'b1;
    res_next.sda_out    = 1'b1;
    res_next.sda_drive  = 1'b1;
    res_next.busy_res   = 1'b1;

    case (phase)
      PH_IDLE: begin
        res_next.busy_res = 1'b0;
        if (req_ch.start_cmd) begin
          latched_command_next  = req_ch.req_type;
          latched_register_next = req_ch.reg_addr;
          latched_data_next     = req_ch.wr_data;
          error_flag_next       = 1'b0;
          if (req_ch.req_type == REQ_BURST) begin
            bytes_left_next = (bl_ext > max_ext) ? BLW'(max_ext) : BLW'(bl_ext);
          end else if (req_ch.req_type == REQ_READ) begin
            bytes_left_next = BLW'(1);
          end else begin
            bytes_left_next = '0;
          end
          // command tick doubles as the (1,1) start slot
          phase_next        = PH_START1;
          bit_index_next    = 4'd2;
          res_next.busy_res = 1'b1;
        end
      end
      PH_START1, PH_START2: begin
        res_next.scl_out = (idx == 2'd1) || (idx == 2'd2);
        res_next.sda_out = (idx == 2'd0) || (idx == 2'd1);
        if (idx == 2'd3) begin
          bit_index_next = '0;
          if (phase == PH_START1) begin
            phase_next      = PH_ADDR_W;
            shift_byte_next = device_write_address;
          end else begin
            phase_next      = PH_ADDR_R;
            shift_byte_next = device_write_address | BYTE_W'(1);
          end
        end else begin
          bit_index_next = {2'b00, idx + 2'd1};
        end
      end
      PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R: begin
        res_next.scl_out = bit_index[0];
        res_next.sda_out = shift_byte[BYTE_W-1];
        if (bit_index[0]) begin
          shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
        end
        if (bit_index == 4'd15) begin
          bit_index_next      = '0;
          ack_wait_count_next = '0;
          case (phase)
            PH_ADDR_W: phase_next = (latched_command == REQ_WAKE) ? PH_STOP : PH_ACK1;
            PH_REG:    phase_next = PH_ACK2;
            PH_DATA:   phase_next = PH_ACK3;
            default:   phase_next = PH_ACK4;
          endcase
        end else begin
          bit_index_next = bit_index + 4'd1;
        end
      end
      PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
        res_next.sda_drive = 1'b0;
        if (bit_index == 4'd0) begin
          res_next.scl_out = 1'b0;
          bit_index_next   = 4'd1;
        end else if (req_ch.sda_in && (ack_wait_count < ack_timeout)) begin
          ack_wait_count_next = ack_wait_count + BYTE_W'(1);
        end else begin
          bit_index_next = '0;
          case (phase)
            PH_ACK1: begin
              if (!req_ch.sda_in) begin
                phase_next      = PH_REG;
                shift_byte_next = latched_register;
              end else begin
                error_flag_next = 1'b1;
                phase_next      = PH_STOP;
              end
            end
            PH_ACK2: begin
              if (latched_command == REQ_WRITE) begin
                phase_next      = PH_DATA;
                shift_byte_next = latched_data;
              end else begin
                phase_next = PH_START2;
              end
            end
            PH_ACK4: begin
              if (bytes_left != '0) begin
                phase_next      = PH_READ;
                shift_byte_next = '0;
              end else begin
                phase_next = PH_STOP;
              end
            end
            default: phase_next = PH_STOP;
          endcase
        end
      end
      PH_READ: begin
        res_next.sda_drive = 1'b0;
        res_next.scl_out   = bit_index[0];
        if (bit_index[0]) begin
          shift_byte_next = shift_in;
        end
        if (bit_index == 4'd15) begin
          res_next.read_valid = 1'b1;
          res_next.read_byte  = shift_in;
          res_next.last_byte  = (bytes_left <= BLW'(1));
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - BLW'(1);
          end
          phase_next     = PH_MACK;
          bit_index_next = '0;
        end else begin
          bit_index_next = bit_index + 4'd1;
        end
      end
      PH_MACK: begin
        // ACK while bytes remain, NACK on the last one
        res_next.scl_out = bit_index[0];
        res_next.sda_out = (bytes_left == '0);
        if (bit_index != 4'd0) begin
          bit_index_next = '0;
          if (bytes_left != '0) begin
            phase_next      = PH_READ;
            shift_byte_next = '0;
          end else begin
            phase_next = PH_STOP;
          end
        end else begin
          bit_index_next = 4'd1;
        end
      end
      PH_STOP: begin
        res_next.scl_out = (stop_idx != 2'd0);
        res_next.sda_out = (stop_idx == 2'd2);
        if (stop_idx == 2'd2) begin
          res_next.cmd_done   = 1'b1;
          res_next.nack_error = error_flag;
          // failed single read reports a zero byte
          if (error_flag && (latched_command == REQ_READ)) begin
            res_next.read_valid = 1'b1;
            res_next.last_byte  = 1'b1;
          end
          phase_next     = PH_IDLE;
          bit_index_next = '0;
        end else begin
          bit_index_next = {2'b00, stop_idx + 2'd1};
        end
      end
      default: begin
        res_next.busy_res = 1'b0;
        phase_next        = PH_IDLE;
        bit_index_next    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_index        <= '0;
      shift_byte       <= '0;
      bytes_left       <= '0;
      ack_wait_count   <= '0;
      latched_command  <= '0;
      latched_register <= '0;
      latched_data     <= '0;
      error_flag       <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (req_fire) begin
        phase            <= phase_next;
        bit_index        <= bit_index_next;
        shift_byte       <= shift_byte_next;
        bytes_left       <= bytes_left_next;
        ack_wait_count   <= ack_wait_count_next;
        latched_command  <= latched_command_next;
        latched_register <= latched_register_next;
        latched_data     <= latched_data_next;
        error_flag       <= error_flag_next;
        res_valid        <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_q <= res_next;
    end
  end

  assign res_ch.valid      = res_valid;
  assign res_ch.scl_out    = res_q.scl_out;
  assign res_ch.sda_out    = res_q.sda_out;
  assign res_ch.sda_drive  = res_q.sda_drive;
  assign res_ch.busy_res   = res_q.busy_res;
  assign res_ch.read_valid = res_q.read_valid;
  assign res_ch.read_byte  = res_q.read_byte;
  assign res_ch.last_byte  = res_q.last_byte;
  assign res_ch.cmd_done   = res_q.cmd_done;
  assign res_ch.nack_error = res_q.nack_error;

`ifndef SYNTHESIS
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid && res_ch.nack_error |-> res_ch.cmd_done)
    else $error("nack_error without cmd_done");

  a_read_fields_clean: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid && !res_ch.read_valid |-> (res_ch.read_byte == '0) && !res_ch.last_byte)
    else $error("read fields set without read_valid");

  a_idle_tick_not_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire && (phase == PH_IDLE) && !req_ch.start_cmd |=> !res_ch.busy_res)
    else $error("idle tick reported busy");

  a_ack_bit_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ACK1 || phase == PH_ACK2 || phase == PH_ACK3 || phase == PH_ACK4)
      |-> (bit_index <= 4'd1))
    else $error("acknowledge slot counter out of range");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= BLW'(MAX_BURST))
    else $error("bytes_left above burst limit");
`endif

endmodule
